@@ hw/rtl/rspe_pkg.sv @@
// Shared types, constants and GF(2^8) arithmetic for the Reed-Solomon parity encoder.
package rspe_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_W       = 6;
    localparam int unsigned RESET_COUNT = 10;
    localparam logic [8:0]  FIELD_POLY  = 9'h11d;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_BUILD,
        CELL_ENCODE,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     at_step;     // this cell takes the implicit leading one
        logic     below_step;  // this cell already holds a generator coefficient
    } t_cell_ctrl;

    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
        return {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? FIELD_POLY[BYTE_W-1:0] : '0);
    endfunction

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < BYTE_W; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_xtime(sh);
        end
        return acc;
    endfunction

endpackage

@@ hw/rtl/rspe_if.sv @@
// Valid/ready channel interfaces for data input, parity output and configuration.
interface rspe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       message_end;

    modport source (output valid, output data_byte, output message_end, input ready);
    modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface rspe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] parity_byte;
    logic       parity_last;

    modport source (output valid, output parity_byte, output parity_last, input ready);
    modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface

interface rspe_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] parity_count;

    modport source (output valid, output parity_count, input ready);
    modport sink   (input valid, input parity_count, output ready);
endinterface

@@ hw/rtl/rspe_cell.sv @@
// One cell of the chain: a generator coefficient and a parity byte with one shared GF multiplier.
module rspe_cell (
    input  logic               i_clk,
    input  rspe_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]         i_mul_op,
    input  logic [7:0]         i_prev_gen,
    input  logic [7:0]         i_prev_par,
    output logic [7:0]         o_gen,
    output logic [7:0]         o_par
);
    import rspe_pkg::*;

    logic [7:0] r_gen;
    logic [7:0] r_par;
    logic [7:0] n_gen;
    logic [7:0] n_par;
    logic [7:0] mul_b;
    logic [7:0] prod;

    // A zero coefficient acts as one in encoding (log of zero reads as zero).
    always_comb begin
        if (i_ctrl.op == CELL_BUILD) begin
            mul_b = i_ctrl.at_step ? 8'h01 : r_gen;
        end else begin
            mul_b = (r_gen == '0) ? 8'h01 : r_gen;
        end
    end

    assign prod = gf_mul(mul_b, i_mul_op);

    always_comb begin
        n_gen = r_gen;
        n_par = r_par;
        case (i_ctrl.op)
            CELL_CLEAR: begin
                n_gen = '0;
                n_par = '0;
            end
            CELL_BUILD: begin
                if (i_ctrl.at_step || i_ctrl.below_step) begin
                    n_gen = i_prev_gen ^ prod;
                end
            end
            CELL_ENCODE: n_par = i_prev_par ^ prod;
            CELL_SHIFT:  n_par = i_prev_par;
            default: begin
                n_gen = r_gen;
                n_par = r_par;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_gen <= n_gen;
        r_par <= n_par;
    end

    assign o_gen = r_gen;
    assign o_par = r_par;

endmodule

@@ hw/rtl/reed_solomon_parity_encoder_top.sv @@
// Reed-Solomon GF(2^8) parity encoder: a chain of multiply cells and its sequencer.
// Throughput: one data byte per cycle in S_RUN; then n parity bytes, one per cycle while ready.
// The first parity byte is offered in the cycle after the end byte is taken.
// After reset or a count write, S_CLEAR then S_BUILD build the generator; no data is taken then.
// Reset (synchronous, active low) restores a count of 10, clears parity and rebuilds.
module reed_solomon_parity_encoder_top #(
    parameter int unsigned MAX_PARITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rspe_in_if.sink     i_data,
    rspe_out_if.source  o_parity,
    rspe_cfg_if.sink    i_cfg
);
    import rspe_pkg::*;

    localparam int unsigned CW      = $clog2(MAX_PARITY + 1);
    localparam int unsigned IW      = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int unsigned RESET_N = (RESET_COUNT > MAX_PARITY) ? MAX_PARITY : RESET_COUNT;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_BUILD,
        S_RUN,
        S_UNLOAD
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_step, n_step;
    logic [IW-1:0]   r_idx, n_idx;
    logic [7:0]      r_alpha, n_alpha;

    logic [CW-1:0]   cfg_count;
    logic [CW-1:0]   cnt_m1;
    logic            cfg_fire;
    logic            in_fire;
    logic            out_fire;
    logic [7:0]      tail;
    logic [7:0]      mul_op;
    t_cell_op        cell_op;

    logic [7:0]      gen      [MAX_PARITY];
    logic [7:0]      par      [MAX_PARITY];
    logic [7:0]      prev_gen [MAX_PARITY];
    logic [7:0]      prev_par [MAX_PARITY];
    t_cell_ctrl      ctrl     [MAX_PARITY];

    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign in_fire  = i_data.valid && i_data.ready;
    assign out_fire = o_parity.valid && o_parity.ready;
    assign cnt_m1   = r_count - CW'(1);
    assign tail     = par[cnt_m1[IW-1:0]];

    assign i_cfg.ready       = 1'b1;
    assign i_data.ready      = (r_state == S_RUN);
    assign o_parity.valid    = (r_state == S_UNLOAD);
    assign o_parity.parity_byte = tail;
    assign o_parity.parity_last = (r_idx == cnt_m1[IW-1:0]);

    // Clamp the written count into 1..MAX_PARITY.
    always_comb begin
        if (i_cfg.parity_count == '0) begin
            cfg_count = CW'(1);
        end else if (int'(i_cfg.parity_count) > int'(MAX_PARITY)) begin
            cfg_count = CW'(MAX_PARITY);
        end else begin
            cfg_count = CW'(i_cfg.parity_count);
        end
    end

    always_comb begin
        mul_op = (r_state == S_BUILD) ? r_alpha : (i_data.data_byte ^ tail);
        unique case (r_state)
            S_CLEAR:  cell_op = CELL_CLEAR;
            S_BUILD:  cell_op = CELL_BUILD;
            S_RUN:    cell_op = in_fire ? CELL_ENCODE : CELL_HOLD;
            S_UNLOAD: cell_op = out_fire ? CELL_SHIFT : CELL_HOLD;
            default:  cell_op = CELL_HOLD;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_step  = r_step;
        n_idx   = r_idx;
        n_alpha = r_alpha;
        unique case (r_state)
            S_CLEAR: begin
                n_step  = '0;
                n_alpha = 8'h01;
                n_state = S_BUILD;
            end
            S_BUILD: begin
                n_step  = r_step + IW'(1);
                n_alpha = gf_xtime(r_alpha);
                if (r_step == cnt_m1[IW-1:0]) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (in_fire && i_data.message_end) begin
                    n_idx   = '0;
                    n_state = S_UNLOAD;
                end
            end
            S_UNLOAD: begin
                if (out_fire) begin
                    n_idx = r_idx + IW'(1);
                    if (r_idx == cnt_m1[IW-1:0]) begin
                        n_state = S_RUN;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
        // A count write drops any message in flight and restarts the build.
        if (cfg_fire) begin
            n_count = cfg_count;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_count <= CW'(RESET_N);
            r_step  <= '0;
            r_idx   <= '0;
            r_alpha <= 8'h01;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_alpha <= n_alpha;
        end
    end

    for (genvar d = 0; d < MAX_PARITY; d++) begin : g_cell
        if (d == 0) begin : g_head
            assign prev_gen[d] = '0;
            assign prev_par[d] = '0;
        end else begin : g_link
            assign prev_gen[d] = gen[d-1];
            assign prev_par[d] = par[d-1];
        end

        assign ctrl[d].op         = cell_op;
        assign ctrl[d].at_step    = (r_step == IW'(d));
        assign ctrl[d].below_step = (IW'(d) < r_step);

        rspe_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl[d]),
            .i_mul_op   (mul_op),
            .i_prev_gen (prev_gen[d]),
            .i_prev_par (prev_par[d]),
            .o_gen      (gen[d]),
            .o_par      (par[d])
        );
    end

    a_no_input_during_unload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_data.ready && o_parity.valid))
        else $error("data accepted while parity is being delivered");

    a_end_starts_unload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_data.message_end && !cfg_fire) |=> o_parity.valid)
        else $error("end byte did not start parity delivery");

    a_last_resumes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_parity.parity_last && !cfg_fire) |=> i_data.ready)
        else $error("input not resumed after last parity byte");

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> (!i_data.ready && !o_parity.valid))
        else $error("channels active right after count write");

endmodule

@@ verif/tb_reed_solomon_parity_encoder_top.sv @@
// Self-checking testbench for the GF(2^8) Reed-Solomon parity encoder, with its own parity predictor.
module tb_reed_solomon_parity_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_PARITY    = 32;
    localparam int          CLK_HALF      = 10;
    localparam int          RANDOM_ITEMS  = 255;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          MAX_REPORTS   = 40;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       parity_last;
    } t_parity_item;

    logic i_clk;
    logic i_rst_n;

    rspe_in_if  data_ch ();
    rspe_out_if parity_ch ();
    rspe_cfg_if cfg_ch ();

    reed_solomon_parity_encoder_top #(
        .MAX_PARITY(MAX_PARITY)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (data_ch),
        .o_parity (parity_ch),
        .i_cfg    (cfg_ch)
    );

    // GF(2^8) log / antilog lookup, field polynomial 0x11d
    logic [7:0] exp_of [0:255];
    logic [7:0] log_of [0:255];

    // predictor state
    logic [7:0] lfsr_bytes [MAX_PARITY];
    logic [7:0] gen_log_coef [MAX_PARITY];
    bit         gen_built;
    int         active_count;

    t_parity_item pending_parity [$];

    bit steady_flow;
    int mismatches;
    int messages_sent;
    int bytes_sent;
    int parity_checked;
    int count_writes;

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin : watchdog
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        mismatches++;
    endtask

    function automatic void build_field_lookup();
        logic [8:0] b;
        b = 9'h001;
        for (int i = 0; i < 256; i++) begin
            log_of[i] = 8'h00;
        end
        for (int i = 0; i < 255; i++) begin
            exp_of[i] = b[7:0];
            log_of[b[7:0]] = i[7:0];
            b = b << 1;
            if (b[8]) begin
                b = b ^ 9'h11d;
            end
        end
        exp_of[255] = 8'h01;
    endfunction

    function automatic logic [7:0] times_alpha_pow(input logic [7:0] a, input int e);
        if (a == 8'h00) begin
            return 8'h00;
        end
        return exp_of[(int'(log_of[a]) + e) % 255];
    endfunction

    function automatic void build_generator_logs();
        logic [7:0] coef [MAX_PARITY];
        for (int i = 0; i < active_count; i++) begin
            coef[i] = 8'h01;
            for (int j = i; j > 0; j--) begin
                coef[j] = coef[j-1] ^ times_alpha_pow(coef[j], i);
            end
            coef[0] = times_alpha_pow(coef[0], i);
        end
        // store highest-order low coefficient first
        for (int i = 0; i < active_count; i++) begin
            gen_log_coef[i] = log_of[coef[active_count-1-i]];
        end
        gen_built = 1'b1;
    endfunction

    function automatic void apply_parity_count(input logic [5:0] value);
        if (value == 6'd0) begin
            active_count = 1;
        end else if (int'(value) > MAX_PARITY) begin
            active_count = MAX_PARITY;
        end else begin
            active_count = int'(value);
        end
        for (int j = 0; j < MAX_PARITY; j++) begin
            lfsr_bytes[j] = 8'h00;
        end
        gen_built = 1'b0;
    endfunction

    // Divide one byte into the parity register; on message end, queue the parity bytes.
    function automatic void absorb_data_byte(input logic [7:0] data, input logic is_end);
        logic [7:0] fb;
        int         fb_log;
        t_parity_item item;
        if (!gen_built) begin
            build_generator_logs();
        end
        fb = data ^ lfsr_bytes[0];
        if (fb != 8'h00) begin
            fb_log = int'(log_of[fb]);
            for (int j = 0; j + 1 < active_count; j++) begin
                lfsr_bytes[j] = lfsr_bytes[j+1] ^
                    exp_of[(fb_log + int'(gen_log_coef[j])) % 255];
            end
            lfsr_bytes[active_count-1] =
                exp_of[(fb_log + int'(gen_log_coef[active_count-1])) % 255];
        end else begin
            for (int j = 0; j + 1 < active_count; j++) begin
                lfsr_bytes[j] = lfsr_bytes[j+1];
            end
            lfsr_bytes[active_count-1] = 8'h00;
        end
        if (is_end) begin
            for (int j = 0; j < active_count; j++) begin
                item.parity_byte = lfsr_bytes[j];
                item.parity_last = (j + 1 == active_count);
                pending_parity.push_back(item);
            end
            for (int j = 0; j < MAX_PARITY; j++) begin
                lfsr_bytes[j] = 8'h00;
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic is_end);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            data_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        data_ch.valid       <= 1'b1;
        data_ch.data_byte   <= data;
        data_ch.message_end <= is_end;
        do @(posedge i_clk); while (!data_ch.ready);
        absorb_data_byte(data, is_end);
        bytes_sent++;
        if (is_end) begin
            messages_sent++;
        end
    endtask

    // Drop valid and hold until every queued parity byte has come out.
    task automatic wait_idle();
        @(negedge i_clk);
        data_ch.valid <= 1'b0;
        while (pending_parity.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_parity_count(input logic [5:0] value);
        wait_idle();
        @(negedge i_clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.parity_count <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_parity_count(value);
        count_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : parity_sink
        int stall;
        t_parity_item want;
        parity_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 8);
            @(negedge i_clk);
            if (stall > 0) begin
                parity_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            parity_ch.ready <= 1'b1;
            do @(posedge i_clk); while (parity_ch.valid !== 1'b1);
            parity_checked++;
            if (pending_parity.size() == 0) begin
                report_mismatch($sformatf("unexpected parity byte %02h last=%0b",
                                          parity_ch.parity_byte, parity_ch.parity_last));
            end else begin
                want = pending_parity.pop_front();
                if (parity_ch.parity_byte !== want.parity_byte) begin
                    report_mismatch($sformatf("parity_byte got %02h want %02h",
                                              parity_ch.parity_byte, want.parity_byte));
                end
                if (parity_ch.parity_last !== want.parity_last) begin
                    report_mismatch($sformatf("parity_last got %0b want %0b",
                                              parity_ch.parity_last, want.parity_last));
                end
            end
        end
    end

    // Single-byte messages at the reset count of 10.
    task automatic test_reset_count();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
    endtask

    // Feed the byte equal to the head of the register so the feedback is zero.
    task automatic test_zero_feedback();
        send_byte(8'h37, 1'b0);
        send_byte(lfsr_bytes[0], 1'b0);
        send_byte(lfsr_bytes[0], 1'b1);
    endtask

    task automatic test_count_limits();
        write_parity_count(6'd0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'h3c, 1'b1);
        write_parity_count(6'd63);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        write_parity_count(6'd1);
        send_byte(8'h5a, 1'b1);
        write_parity_count(6'd32);
        send_byte(8'h12, 1'b0);
        send_byte(8'hed, 1'b1);
    endtask

    // A count write in the middle of a message discards the partial parity.
    task automatic test_write_mid_message();
        send_byte(8'h9e, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h07, 1'b0);
        write_parity_count(6'd5);
        send_byte(8'h66, 1'b0);
        send_byte(8'hb2, 1'b1);
    endtask

    task automatic test_random_messages();
        int sent;
        int msg_len;
        int msgs_in_run;
        logic [7:0] value;
        logic [7:0] pick;
        sent = 0;
        msgs_in_run = 0;
        while (sent < RANDOM_ITEMS) begin
            // occasionally leave a partial message behind before the write
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                    sent++;
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                value = 8'($urandom_range(0, 63));
            end else begin
                value = 8'($urandom_range(1, 32));
            end
            write_parity_count(value[5:0]);
            steady_flow = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 8)) begin
                // stop starting new messages once the budget is spent
                if (sent < RANDOM_ITEMS) begin
                    msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 10);
                    for (int k = 0; k < msg_len; k++) begin
                        case ($urandom_range(0, 9))
                            0:       pick = 8'h00;
                            1:       pick = 8'hff;
                            2:       pick = lfsr_bytes[0];
                            default: pick = 8'($urandom_range(0, 255));
                        endcase
                        send_byte(pick, k == msg_len - 1);
                        sent++;
                    end
                    msgs_in_run++;
                    if (msgs_in_run % 9 == 4) begin
                        wait_idle();
                    end
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin : main_sequence
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        data_ch.valid        = 1'b0;
        data_ch.data_byte    = 8'h00;
        data_ch.message_end  = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.parity_count  = 6'd0;
        steady_flow          = 1'b0;
        mismatches           = 0;
        messages_sent        = 0;
        bytes_sent           = 0;
        parity_checked       = 0;
        count_writes         = 0;
        build_field_lookup();
        apply_parity_count(6'(rspe_pkg::RESET_COUNT));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_count();
        test_byte_extremes();
        test_zero_feedback();
        test_count_limits();
        test_write_mid_message();
        test_random_messages();

        wait_idle();
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d data bytes in %0d messages, %0d count writes.",
                 bytes_sent, messages_sent, count_writes);
        $display("Parity bytes checked: %0d, mismatches: %0d.", parity_checked, mismatches);
        if (mismatches == 0 && pending_parity.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
